### hw/rtl/medrc_pkg.sv
`default_nettype none

package medrc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int VAL_W      = 9;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = CFG_DATA_W'(1024);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_cfg_reg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Median edge predictor.
    function automatic logic [PIX_W-1:0] med_predict(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c >= hi) begin
            med_predict = lo;
        end else if (c <= lo) begin
            med_predict = hi;
        end else begin
            med_predict = PIX_W'(a + b - c);
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/medrc_ram.sv
`default_nettype none

module medrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/med_predict_residual_codec.sv
// An accepted request is held in the first stage and moves into the output register when it
// advances. One request per clock while the output is not stalled; the line store is read
// when a request is accepted and written when the request leaves the first stage, so the
// single read and single write port set this rate.
// Reset (synchronous, active low) clears the counters, neighbours, pipeline valids and
// configuration (encode, 1024 by 1024); the line store is not cleared and needs no pass.
`default_nettype none

module med_predict_residual_codec #(
    parameter int MAX_WIDTH  = medrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = medrc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [medrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [medrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [medrc_pkg::VAL_W-1:0]       i_in_value,
    // Output channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [medrc_pkg::VAL_W-1:0]       o_result_value,
    output logic                                   o_plane_end
);

    import medrc_pkg::*;

    // Column counter indexes the line store; the row counter only needs to reach
    // the height. Comparison widths cover both the register and the parameter.
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WBITS  = $clog2(MAX_WIDTH + 1);
    localparam int HBITS  = $clog2(MAX_HEIGHT + 1);
    localparam int DW     = (WBITS > CFG_DATA_W) ? WBITS : CFG_DATA_W;
    localparam int HW     = (HBITS > CFG_DATA_W) ? HBITS : CFG_DATA_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                  r_direction;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
            r_width     <= DIM_RESET;
            r_height    <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIRECTION: begin
                    r_direction <= i_cfg_data[0];
                end
                REG_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                REG_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Effective dimensions: zero counts as one, anything above MAX_WIDTH or MAX_HEIGHT saturates.
    logic [DW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = DW'(1);
        end else if (DW'(r_width) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HW'(1);
        end else if (HW'(r_height) > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The first stage holds an accepted request while its upper
    // neighbour is read from the line store; the second step computes the
    // result and loads the output register. A request leaves the first stage
    // whenever the output register is empty or is being taken.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic advance;
    logic in_accept;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Raster position. The position depends only on the count of requests, so
    // it advances at acceptance and the store read for the request goes out
    // at that same edge.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          n_end;
    logic [DW-1:0] col_inc;
    logic [HW-1:0] row_inc;

    always_comb begin
        col_inc = DW'(r_col) + DW'(1);
        row_inc = HW'(r_row) + HW'(1);
        n_col   = CW'(col_inc);
        n_row   = r_row;
        n_end   = 1'b0;
        if (col_inc >= w_eff) begin
            n_col = '0;
            if (row_inc >= h_eff) begin
                n_row = '0;
                n_end = 1'b1;
            end else begin
                n_row = RW'(row_inc);
            end
        end
    end

    // First stage registers.
    logic [VAL_W-1:0] r_s1_value;
    logic [CW-1:0]    r_s1_col;
    logic             r_s1_first_col;
    logic             r_s1_first_row;
    logic             r_s1_end;
    // Forwarding: the store returns old data when it is read at the address
    // being written in the same cycle (only when the row is one pixel wide).
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_pix;

    // Neighbour registers.
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upleft;

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] store_rdata;
    logic [PIX_W-1:0] pixel;

    medrc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_s1_col),
        .i_wdata (pixel),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // Prediction and residue mapping.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] nb_a;
    logic [PIX_W-1:0] nb_b;
    logic [PIX_W-1:0] nb_c;
    logic [PIX_W-1:0] pred;
    logic [VAL_W-1:0] residue;
    logic [VAL_W:0]   residue_x2;
    logic [VAL_W-1:0] code;
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] result;

    always_comb begin
        nb_a = r_s1_first_col ? '0 : r_left;
        nb_b = r_s1_first_row ? '0 : (r_fwd ? r_fwd_pix : store_rdata);
        nb_c = (r_s1_first_col || r_s1_first_row) ? '0 : r_upleft;
        pred = med_predict(nb_a, nb_b, nb_c);

        // Encode: the residue lies in -255..255; a negative one maps to -2r-1,
        // which is the bitwise complement of 2r.
        residue    = VAL_W'(r_s1_value[PIX_W-1:0]) - VAL_W'(pred);
        residue_x2 = {residue, 1'b0};
        code       = residue[VAL_W-1] ? VAL_W'(~residue_x2) : VAL_W'(residue_x2);

        // Decode: an even code is +code/2, an odd one -(code+1)/2. The largest
        // odd code unmaps to -256, which leaves the prediction unchanged.
        mag = VAL_W'(r_s1_value[VAL_W-1:1]) + VAL_W'(r_s1_value[0]);

        if (r_direction == DIR_DECODE) begin
            if (r_s1_value[0]) begin
                pixel = pred - mag[PIX_W-1:0];
            end else begin
                pixel = pred + mag[PIX_W-1:0];
            end
            result = VAL_W'(pixel);
        end else begin
            pixel  = r_s1_value[PIX_W-1:0];
            result = code;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_upleft    <= '0;
        end else begin
            if (in_accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
                r_fwd      <= advance && (r_s1_col == r_col);
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end

            if (advance) begin
                r_left      <= pixel;
                r_upleft    <= nb_b;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_value     <= i_in_value;
            r_s1_col       <= r_col;
            r_s1_first_col <= (r_col == '0);
            r_s1_first_row <= (r_row == '0);
            r_s1_end       <= n_end;
            r_fwd_pix      <= pixel;
        end
        if (advance) begin
            o_result_value <= result;
            o_plane_end    <= r_s1_end;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The input is only held off when both stages are occupied and the output waits.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // A forwarded upper neighbour always belongs to the same column as the request before.
    a_fwd_same_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_fwd) |-> (r_s1_col == $past(r_s1_col)))
        else $error("forwarding used across different columns");

    // A result only appears after a request has been waiting in the first stage.
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a request");

endmodule

`default_nettype wire
